// ----- rtl/bdch_pkg.sv -----
// Shared types and codes for the button debounce and click/hold qualifier.
// Used by bdch_cfg, bdch_core and button_debounce_click_hold; no dependencies.
`timescale 1ns / 1ps

package bdch_pkg;

	localparam int DebounceW = 10;
	localparam int HoldW = 16;
	localparam int CfgDataW = 16;

	localparam logic [DebounceW-1:0] DEBOUNCE_RESET = 10'd20;
	localparam logic [HoldW-1:0] HOLD_RESET = 16'd500;

	// Operation codes of an input word.
	localparam logic [1:0] OP_PIN = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_TAKE = 2'd2;

	// Event codes.
	localparam logic [1:0] EVT_NONE = 2'd0;
	localparam logic [1:0] EVT_CLICK = 2'd1;
	localparam logic [1:0] EVT_HELD = 2'd2;

	// Configuration register indexes.
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_HOLD = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic raw_level;
	} item_t;

	typedef struct packed {
		logic [1:0] event_res;
		logic pressed;
	} result_t;

	typedef struct packed {
		logic [DebounceW-1:0] debounce_ticks;
		logic [HoldW-1:0] hold_ticks;
	} cfg_t;

endpackage

// ----- rtl/bdch_cfg.sv -----
// Configuration registers of the button qualifier: debounce and hold limits.
// Depends on bdch_pkg.
`timescale 1ns / 1ps

module bdch_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bdch_pkg::CfgDataW-1:0] cfg_data,
	output bdch_pkg::cfg_t cfg
);
	import bdch_pkg::*;

	logic [DebounceW-1:0] debounce_q;
	logic [HoldW-1:0] hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			hold_q <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[DebounceW-1:0];
				REG_HOLD: hold_q <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.debounce_ticks = debounce_q;
	assign cfg.hold_ticks = hold_q;

endmodule

// ----- rtl/bdch_core.sv -----
// Debounce, hold timing and event state of the button qualifier.
// Computes the result of one word and updates the state. Depends on bdch_pkg.
`timescale 1ns / 1ps

module bdch_core (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  bdch_pkg::item_t item,
	input  bdch_pkg::cfg_t cfg,
	output bdch_pkg::result_t result
);
	import bdch_pkg::*;

	logic raw_q, raw_n;
	logic [DebounceW-1:0] settle_q, settle_n;
	logic stable_q, stable_n;
	logic prev_q, prev_n;
	logic [HoldW-1:0] hold_q, hold_n, hold_inc;
	logic done_q, done_n;
	logic [1:0] pend_q, pend_n;
	logic [1:0] ev;
	logic [1:0] taken;

	always_comb begin
		raw_n = raw_q;
		settle_n = settle_q;
		stable_n = stable_q;
		prev_n = prev_q;
		hold_n = hold_q;
		done_n = done_q;
		pend_n = pend_q;
		hold_inc = hold_q;
		ev = EVT_NONE;
		taken = EVT_NONE;
		unique case (item.operation)
			OP_PIN: begin
				raw_n = item.raw_level;
				settle_n = cfg.debounce_ticks;
			end
			OP_TICK: begin
				if (settle_q != '0) begin
					settle_n = settle_q - 1'b1;
					if (settle_n == '0) begin
						// The pin is active low.
						stable_n = ~raw_q;
						if (stable_n && !prev_q) begin
							hold_n = '0;
							done_n = 1'b0;
						end else if (!stable_n && prev_q) begin
							if (!done_q) begin
								ev = EVT_CLICK;
							end
							hold_n = '0;
						end
						prev_n = stable_n;
					end
				end
				if (stable_n && !done_n) begin
					hold_inc = hold_n + 1'b1;
					hold_n = hold_inc;
					if (hold_inc >= cfg.hold_ticks) begin
						ev = EVT_HELD;
						done_n = 1'b1;
					end
				end
				if (ev != EVT_NONE) begin
					pend_n = ev;
				end
			end
			OP_TAKE: begin
				taken = pend_q;
				pend_n = EVT_NONE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= 1'b0;
			settle_q <= '0;
			stable_q <= 1'b0;
			prev_q <= 1'b0;
			hold_q <= '0;
			done_q <= 1'b0;
			pend_q <= EVT_NONE;
		end else if (en) begin
			raw_q <= raw_n;
			settle_q <= settle_n;
			stable_q <= stable_n;
			prev_q <= prev_n;
			hold_q <= hold_n;
			done_q <= done_n;
			pend_q <= pend_n;
		end
	end

	assign result.event_res = taken;
	assign result.pressed = stable_n;

	// Taking an event always leaves nothing pending.
	a_take_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && item.operation == OP_TAKE |=> pend_q == EVT_NONE)
		else $error("pending event not cleared by take");

	// No word means no state change.
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({raw_q, settle_q, stable_q, prev_q, hold_q, done_q, pend_q}))
		else $error("state changed without a word");

	// A pressed level can only change on a tick that finishes the settle countdown.
	a_level_change: assert property (@(posedge clk) disable iff (!arst_n)
		stable_n != stable_q && en |-> item.operation == OP_TICK && settle_q == 10'd1)
		else $error("debounced level changed outside a settle completion");

	// After a held event for this press, no click can follow until a new press.
	a_no_click_after_held: assert property (@(posedge clk) disable iff (!arst_n)
		en && done_q && stable_q && stable_n |-> ev != EVT_CLICK)
		else $error("click raised while a press is already held");

endmodule

// ----- rtl/button_debounce_click_hold.sv -----
// Top level of the button debounce and click/hold qualifier.
// Depends on bdch_pkg, bdch_cfg and bdch_core.
`timescale 1ns / 1ps

// One active-low button pin is qualified from a stream of words: pin change,
// timer tick or take event. Each accepted word yields exactly one result word
// carrying the taken event (none, click or held) and the debounced level. The
// block accepts a word every cycle unless item_stall is high. A word is held in
// the input register, and its result is registered in the result register and
// offered on res. All state is updated at the same edge that loads the result
// register. When both registers hold words and the result is stalled, the input
// register holds and item_stall rises. The user must write configuration only
// while no word is in flight; the block itself does not enforce this.
module button_debounce_click_hold (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [bdch_pkg::CfgDataW-1:0] cfg_data,
	input  logic item_valid,
	output logic item_stall,
	input  bdch_pkg::item_t item,
	output logic res_valid,
	input  logic res_stall,
	output bdch_pkg::result_t res
);
	import bdch_pkg::*;

	cfg_t cfg;
	item_t item_s1;
	logic valid_s1;
	logic advance;
	result_t core_res;
	result_t res_q;
	logic res_valid_q;

	bdch_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// The input register moves on whenever the result register is free or draining.
	assign advance = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	bdch_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.item(item_s1),
		.cfg(cfg),
		.result(core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	// A word held in the input register is only stalled behind a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled without a stalled result");

endmodule
